/* rtl/core/cpu6502_execute_unit_assert.svh */
// assertion macros used by the checker file
`ifndef CPU6502_EXECUTE_UNIT_ASSERT_SVH
`define CPU6502_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication, checked after reset
`define C65_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication, checked after reset
`define C65_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

/* rtl/core/c65eu_pkg.sv */
// types, constants and operation codes of the 6502 execute unit
package c65eu_pkg;

    localparam int QueueDepth = 2;

    localparam logic [15:0] StackPage = 16'h0100;
    localparam logic [7:0]  SpReset   = 8'hFD;
    localparam logic [7:0]  FlagReset = 8'h24;

    localparam int FC = 0;
    localparam int FZ = 1;
    localparam int FI = 2;
    localparam int FD = 3;
    localparam int FB = 4;
    localparam int FU = 5;
    localparam int FV = 6;
    localparam int FN = 7;

    typedef enum logic [5:0] {
        M_LDA, M_STA, M_LDX, M_STX, M_LDY, M_STY, M_TAX, M_TAY, M_TXA, M_TYA,
        M_ADC, M_SBC, M_INC, M_DEC, M_INX, M_DEX, M_INY, M_DEY, M_ASL, M_ASL_A,
        M_LSR, M_LSR_A, M_ROL, M_ROL_A, M_ROR, M_ROR_A, M_AND, M_ORA, M_EOR, M_BIT,
        M_CMP, M_CPX, M_CPY, M_JMP, M_JSR, M_RTS, M_BRK, M_RTI, M_PHA, M_PLA,
        M_PHP, M_PLP, M_TSX, M_TXS, M_NOP, M_CLC, M_SEC, M_CLI, M_SEI, M_CLD,
        M_SED, M_CLV
    } t_mode;

    typedef struct packed {
        logic [5:0]  mode;
        logic [15:0] address;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [7:0]  data_third;
    } t_in_item;

    typedef struct packed {
        logic        bus_write;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
        logic [7:0]  acc_out;
        logic [7:0]  x_out;
        logic [7:0]  y_out;
        logic [7:0]  sp_out;
        logic [7:0]  flags_out;
        logic [15:0] pc_out;
        logic        last;
    } t_out_item;

    // classification made by the front part
    typedef struct packed {
        logic [1:0] n_wr;
        logic       rmw;
    } t_cls;

    typedef struct packed {
        t_in_item item;
        t_cls     cls;
    } t_q_entry;

endpackage

/* rtl/core/c65eu_front.sv */
// front part: accepts items and classifies them by bus write count and read-modify-write
module c65eu_front (
    input  logic                i_valid,
    input  c65eu_pkg::t_in_item i_item,
    output logic                o_stall,
    output logic                o_valid,
    output c65eu_pkg::t_q_entry o_entry,
    input  logic                i_stall
);
    import c65eu_pkg::*;

    t_cls cls;

    always_comb begin
        cls = '0;
        unique case (t_mode'(i_item.mode))
            M_STA, M_STX, M_STY, M_PHA, M_PHP: cls.n_wr = 2'd1;
            M_INC, M_DEC, M_ASL, M_LSR, M_ROL, M_ROR: begin
                cls.n_wr = 2'd2;
                cls.rmw  = 1'b1;
            end
            M_JSR: cls.n_wr = 2'd2;
            M_BRK: cls.n_wr = 2'd3;
            default: cls.n_wr = 2'd0;
        endcase
    end

    assign o_valid       = i_valid;
    assign o_stall       = i_stall;
    assign o_entry.item  = i_item;
    assign o_entry.cls   = cls;

endmodule

/* rtl/core/c65eu_queue.sv */
// short queue between front and back parts
module c65eu_queue #(
    parameter int Depth = c65eu_pkg::QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    input  c65eu_pkg::t_q_entry i_push_entry,
    output logic                o_push_stall,
    output logic                o_pop_valid,
    output c65eu_pkg::t_q_entry o_pop_entry,
    input  logic                i_pop_stall
);
    import c65eu_pkg::*;

    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

    t_q_entry         r_mem [Depth];
    logic [Aw-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [Aw:0]      r_cnt, n_cnt;
    logic             push, pop;

    assign o_push_stall = (r_cnt == (Aw+1)'(Depth));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_entry  = r_mem[r_rp];
    assign push = i_push_valid && !o_push_stall;
    assign pop  = o_pop_valid && !i_pop_stall;

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (push) begin
            n_wp = (r_wp == Aw'(Depth - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == Aw'(Depth - 1)) ? '0 : r_rp + 1'b1;
        end
        n_cnt = r_cnt + (Aw+1)'(push) - (Aw+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_entry;
        end
    end

endmodule

/* rtl/core/c65eu_back.sv */
// back part: executes operations and sends out their result items
module c65eu_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  c65eu_pkg::t_q_entry  i_entry,
    output logic                 o_stall,
    output logic                 o_valid,
    output c65eu_pkg::t_out_item o_item,
    input  logic                 i_stall
);
    import c65eu_pkg::*;

    function automatic logic [7:0] f_nz(input logic [7:0] f, input logic [7:0] v);
        logic [7:0] t;
        t     = f;
        t[FZ] = (v == 8'h00);
        t[FN] = v[7];
        return t;
    endfunction

    logic [7:0]  r_a, r_x, r_y, r_sp, r_f, n_a, n_x, n_y, n_sp, n_f;
    logic [15:0] r_pc, n_pc;
    logic        r_busy;
    logic [1:0]  r_idx, r_cnt, r_nwr;
    logic [15:0] r_wa [3];
    logic [7:0]  r_wd [3];
    logic [15:0] w_a [3];
    logic [7:0]  w_d [3];

    t_in_item    it;
    logic [7:0]  d1, opnd, rres, cmp_reg;
    logic [8:0]  sum, diff;
    logic [15:0] pcm, pcp, stk0, stk1, stk2;
    logic        c, last, take;

    assign it   = i_entry.item;
    assign d1   = it.data_first;
    assign c    = r_f[FC];
    assign opnd = (t_mode'(it.mode) == M_SBC) ? ~d1 : d1;
    assign sum  = {1'b0, r_a} + {1'b0, opnd} + {8'b0, c};
    assign cmp_reg = (t_mode'(it.mode) == M_CPX) ? r_x :
                     (t_mode'(it.mode) == M_CPY) ? r_y : r_a;
    assign diff = {1'b0, cmp_reg} - {1'b0, d1};
    assign pcm  = r_pc - 16'd1;
    assign pcp  = r_pc + 16'd1;
    assign stk0 = StackPage | {8'h00, r_sp};
    assign stk1 = StackPage | {8'h00, r_sp - 8'd1};
    assign stk2 = StackPage | {8'h00, r_sp - 8'd2};

    assign last = (r_idx == r_cnt);
    assign take = !r_busy || (!i_stall && last);
    assign o_stall = !take;

    always_comb begin
        n_a = r_a; n_x = r_x; n_y = r_y; n_sp = r_sp; n_f = r_f; n_pc = r_pc;
        rres = 8'h00;
        for (int k = 0; k < 3; k++) begin
            w_a[k] = '0;
            w_d[k] = '0;
        end
        unique case (t_mode'(it.mode))
            M_LDA: begin n_a = d1; n_f = f_nz(r_f, d1); end
            M_STA: begin w_a[0] = it.address; w_d[0] = r_a; end
            M_LDX: begin n_x = d1; n_f = f_nz(r_f, d1); end
            M_STX: begin w_a[0] = it.address; w_d[0] = r_x; end
            M_LDY: begin n_y = d1; n_f = f_nz(r_f, d1); end
            M_STY: begin w_a[0] = it.address; w_d[0] = r_y; end
            M_TAX: begin n_x = r_a; n_f = f_nz(r_f, r_a); end
            M_TAY: begin n_y = r_a; n_f = f_nz(r_f, r_a); end
            M_TXA: begin n_a = r_x; n_f = f_nz(r_f, r_x); end
            M_TYA: begin n_a = r_y; n_f = f_nz(r_f, r_y); end
            M_ADC, M_SBC: begin
                n_a = sum[7:0];
                n_f = f_nz(r_f, sum[7:0]);
                n_f[FC] = sum[8];
                n_f[FV] = (r_a[7] ^ sum[7]) & (opnd[7] ^ sum[7]);
            end
            M_INC: rres = d1 + 8'd1;
            M_DEC: rres = d1 - 8'd1;
            M_INX: begin n_x = r_x + 8'd1; n_f = f_nz(r_f, n_x); end
            M_DEX: begin n_x = r_x - 8'd1; n_f = f_nz(r_f, n_x); end
            M_INY: begin n_y = r_y + 8'd1; n_f = f_nz(r_f, n_y); end
            M_DEY: begin n_y = r_y - 8'd1; n_f = f_nz(r_f, n_y); end
            M_ASL: begin rres = {d1[6:0], 1'b0}; n_f[FC] = d1[7]; end
            M_ASL_A: begin
                n_a = {r_a[6:0], 1'b0}; n_f = f_nz(r_f, n_a); n_f[FC] = r_a[7];
            end
            M_LSR: begin rres = {1'b0, d1[7:1]}; n_f[FC] = d1[0]; end
            M_LSR_A: begin
                n_a = {1'b0, r_a[7:1]}; n_f = f_nz(r_f, n_a); n_f[FC] = r_a[0];
            end
            M_ROL: begin rres = {d1[6:0], c}; n_f[FC] = d1[7]; end
            M_ROL_A: begin
                n_a = {r_a[6:0], c}; n_f = f_nz(r_f, n_a); n_f[FC] = r_a[7];
            end
            M_ROR: begin rres = {c, d1[7:1]}; n_f[FC] = d1[0]; end
            M_ROR_A: begin
                n_a = {c, r_a[7:1]}; n_f = f_nz(r_f, n_a); n_f[FC] = r_a[0];
            end
            M_AND: begin n_a = r_a & d1; n_f = f_nz(r_f, n_a); end
            M_ORA: begin n_a = r_a | d1; n_f = f_nz(r_f, n_a); end
            M_EOR: begin n_a = r_a ^ d1; n_f = f_nz(r_f, n_a); end
            M_BIT: begin
                n_f[FZ] = ((r_a & d1) == 8'h00);
                n_f[FN] = d1[7];
                n_f[FV] = d1[6];
            end
            M_CMP, M_CPX, M_CPY: begin
                n_f = f_nz(r_f, diff[7:0]);
                n_f[FC] = ~diff[8];
            end
            M_JMP: n_pc = it.address;
            M_JSR: begin
                w_a[0] = stk0; w_d[0] = pcm[15:8];
                w_a[1] = stk1; w_d[1] = pcm[7:0];
                n_sp = r_sp - 8'd2;
                n_pc = it.address;
            end
            M_RTS: begin
                n_sp = r_sp + 8'd2;
                n_pc = {it.data_second, d1} + 16'd1;
            end
            M_BRK: begin
                w_a[0] = stk0; w_d[0] = pcp[15:8];
                w_a[1] = stk1; w_d[1] = pcp[7:0];
                w_a[2] = stk2; w_d[2] = r_f | 8'h30;
                n_sp = r_sp - 8'd3;
                n_f[FI] = 1'b1;
                n_pc = {it.data_second, d1};
            end
            M_RTI: begin
                n_sp = r_sp + 8'd3;
                n_f = (d1 | 8'h20) & 8'hEF;
                n_pc = {it.data_third, it.data_second};
            end
            M_PHA: begin w_a[0] = stk0; w_d[0] = r_a; n_sp = r_sp - 8'd1; end
            M_PLA: begin n_sp = r_sp + 8'd1; n_a = d1; n_f = f_nz(r_f, d1); end
            M_PHP: begin
                w_a[0] = stk0; w_d[0] = r_f | 8'h30; n_sp = r_sp - 8'd1;
            end
            M_PLP: begin n_sp = r_sp + 8'd1; n_f = (d1 | 8'h20) & 8'hEF; end
            M_TSX: begin n_x = r_sp; n_f = f_nz(r_f, r_sp); end
            M_TXS: n_sp = r_x;
            M_CLC: n_f[FC] = 1'b0;
            M_SEC: n_f[FC] = 1'b1;
            M_CLI: n_f[FI] = 1'b0;
            M_SEI: n_f[FI] = 1'b1;
            M_CLD: n_f[FD] = 1'b0;
            M_SED: n_f[FD] = 1'b1;
            M_CLV: n_f[FV] = 1'b0;
            default: ;
        endcase
        // read-modify-write: dummy write of the old byte, then the result
        if (i_entry.cls.rmw) begin
            w_a[0] = it.address; w_d[0] = d1;
            w_a[1] = it.address; w_d[1] = rres;
            n_f = f_nz(n_f, rres);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0; r_x <= '0; r_y <= '0; r_sp <= SpReset; r_f <= FlagReset;
            r_pc <= '0; r_busy <= 1'b0; r_idx <= '0; r_cnt <= '0; r_nwr <= '0;
        end else if (take) begin
            r_busy <= i_valid;
            if (i_valid) begin
                r_a <= n_a; r_x <= n_x; r_y <= n_y; r_sp <= n_sp; r_f <= n_f;
                r_pc <= n_pc;
                r_idx <= '0;
                r_nwr <= i_entry.cls.n_wr;
                r_cnt <= (i_entry.cls.n_wr == 2'd0) ? 2'd0 : i_entry.cls.n_wr - 2'd1;
            end
        end else if (!i_stall) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_wa[k] <= w_a[k];
                r_wd[k] <= w_d[k];
            end
        end
    end

    assign o_valid = r_busy;
    always_comb begin
        o_item.bus_write   = (r_nwr != 2'd0);
        o_item.bus_address = (r_idx == 2'd3) ? '0 : r_wa[r_idx];
        o_item.bus_data    = (r_idx == 2'd3) ? '0 : r_wd[r_idx];
        o_item.acc_out     = r_a;
        o_item.x_out       = r_x;
        o_item.y_out       = r_y;
        o_item.sp_out      = r_sp;
        o_item.flags_out   = r_f;
        o_item.pc_out      = r_pc;
        o_item.last        = last;
    end

endmodule

/* rtl/core/cpu6502_execute_unit.sv */
// an item's first result passes the queue, then the back part's output register
// one result item per cycle while the output is not stalled; an item yields one result
// item per bus write, or one if it writes none, from the back part's output register
// reset: synchronous active low; A, X, Y and PC clear, SP = 0xFD, status = 0x24
// queue and output are empty after reset
module cpu6502_execute_unit #(
    parameter int QDepth = c65eu_pkg::QueueDepth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  c65eu_pkg::t_in_item  i_in,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output c65eu_pkg::t_out_item o_out,
    input  logic                 i_out_stall
);
    import c65eu_pkg::*;

    logic     f_valid, f_stall, q_valid, q_stall;
    t_q_entry f_entry, q_entry;

    c65eu_front u_front (
        .i_valid (i_in_valid),
        .i_item  (i_in),
        .o_stall (o_in_stall),
        .o_valid (f_valid),
        .o_entry (f_entry),
        .i_stall (f_stall)
    );

    c65eu_queue #(.Depth(QDepth)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_entry (f_entry),
        .o_push_stall (f_stall),
        .o_pop_valid  (q_valid),
        .o_pop_entry  (q_entry),
        .i_pop_stall  (q_stall)
    );

    c65eu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_stall (q_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out),
        .i_stall (i_out_stall)
    );

endmodule

/* rtl/core/c65eu_checker.sv */
// port checker for the execute unit and its bind
`include "cpu6502_execute_unit_assert.svh"

module c65eu_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input c65eu_pkg::t_out_item o_out
);
    import c65eu_pkg::*;

    `C65_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled result changed")
    `C65_ASSERT_IMP(a_nowr_last, i_clk, i_rst_n, o_out_valid && !o_out.bus_write, o_out.last, "result without write is not last")
    `C65_ASSERT_IMP(a_nowr_zero, i_clk, i_rst_n, o_out_valid && !o_out.bus_write, o_out.bus_address == 16'h0000 && o_out.bus_data == 8'h00, "idle bus fields not zero")
    `C65_ASSERT_NXT(a_more, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_out.last, o_out_valid && o_out.bus_write, "missing follow-on write")

endmodule

bind cpu6502_execute_unit c65eu_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

/* verif/tb.sv */
// self-checking testbench of the 6502 execute unit: directed table, then random operations
module tb;
    import c65eu_pkg::*;

    localparam int WatchLimit = 4000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_item  i_in = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;
    logic      i_out_stall = 1'b0;

    cpu6502_execute_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in(i_in), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out(o_out), .i_out_stall(i_out_stall)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the cpu registers
    logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
    logic [15:0] cpu_pc;
    t_out_item   bus_expect[$];
    int          errors = 0;
    int          idle_cycles = 0;

    task automatic report(input string what, input t_out_item got, input t_out_item want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic void put_nz(input logic [7:0] v);
        cpu_p[FZ] = (v == 8'h00);
        cpu_p[FN] = v[7];
    endfunction

    function automatic void add_carry(input logic [7:0] m);
        logic [8:0] s;
        s = {1'b0, cpu_a} + {1'b0, m} + cpu_p[FC];
        cpu_p[FC] = s[8];
        cpu_p[FV] = (cpu_a[7] ^ s[7]) & (m[7] ^ s[7]);
        cpu_a = s[7:0];
        put_nz(cpu_a);
    endfunction

    function automatic void cmp_reg(input logic [7:0] r, input logic [7:0] m);
        cpu_p[FC] = r >= m;
        put_nz(r - m);
    endfunction

    // runs one operation and queues its expected result items, one per bus write or one if it writes nothing
    function automatic void execute_op(input t_in_item it);
        logic [15:0] wa[3];
        logic [7:0]  wd[3];
        logic [15:0] pcv;
        logic [7:0]  d, res;
        logic        c;
        int          nw, n;
        t_out_item   o;
        nw = 0;
        d = it.data_first;
        c = cpu_p[FC];
        res = 8'h00;
        unique case (it.mode)
            M_LDA: begin cpu_a = d; put_nz(d); end
            M_STA: begin wa[0] = it.address; wd[0] = cpu_a; nw = 1; end
            M_LDX: begin cpu_x = d; put_nz(d); end
            M_STX: begin wa[0] = it.address; wd[0] = cpu_x; nw = 1; end
            M_LDY: begin cpu_y = d; put_nz(d); end
            M_STY: begin wa[0] = it.address; wd[0] = cpu_y; nw = 1; end
            M_TAX: begin cpu_x = cpu_a; put_nz(cpu_x); end
            M_TAY: begin cpu_y = cpu_a; put_nz(cpu_y); end
            M_TXA: begin cpu_a = cpu_x; put_nz(cpu_a); end
            M_TYA: begin cpu_a = cpu_y; put_nz(cpu_a); end
            M_ADC: add_carry(d);
            M_SBC: add_carry(~d);
            M_INC: begin res = d + 8'd1; nw = 2; end
            M_DEC: begin res = d - 8'd1; nw = 2; end
            M_INX: begin cpu_x++; put_nz(cpu_x); end
            M_DEX: begin cpu_x--; put_nz(cpu_x); end
            M_INY: begin cpu_y++; put_nz(cpu_y); end
            M_DEY: begin cpu_y--; put_nz(cpu_y); end
            M_ASL: begin cpu_p[FC] = d[7]; res = {d[6:0], 1'b0}; nw = 2; end
            M_ASL_A: begin cpu_p[FC] = cpu_a[7]; cpu_a = {cpu_a[6:0], 1'b0}; put_nz(cpu_a); end
            M_LSR: begin cpu_p[FC] = d[0]; res = {1'b0, d[7:1]}; nw = 2; end
            M_LSR_A: begin cpu_p[FC] = cpu_a[0]; cpu_a = {1'b0, cpu_a[7:1]}; put_nz(cpu_a); end
            M_ROL: begin cpu_p[FC] = d[7]; res = {d[6:0], c}; nw = 2; end
            M_ROL_A: begin cpu_p[FC] = cpu_a[7]; cpu_a = {cpu_a[6:0], c}; put_nz(cpu_a); end
            M_ROR: begin cpu_p[FC] = d[0]; res = {c, d[7:1]}; nw = 2; end
            M_ROR_A: begin cpu_p[FC] = cpu_a[0]; cpu_a = {c, cpu_a[7:1]}; put_nz(cpu_a); end
            M_AND: begin cpu_a &= d; put_nz(cpu_a); end
            M_ORA: begin cpu_a |= d; put_nz(cpu_a); end
            M_EOR: begin cpu_a ^= d; put_nz(cpu_a); end
            M_BIT: begin
                cpu_p[FZ] = (cpu_a & d) == 8'h00;
                cpu_p[FN] = d[7];
                cpu_p[FV] = d[6];
            end
            M_CMP: cmp_reg(cpu_a, d);
            M_CPX: cmp_reg(cpu_x, d);
            M_CPY: cmp_reg(cpu_y, d);
            M_JMP: cpu_pc = it.address;
            M_JSR: begin
                pcv = cpu_pc - 16'd1;
                wa[0] = StackPage + cpu_sp; wd[0] = pcv[15:8];
                wa[1] = StackPage + 8'(cpu_sp - 8'd1); wd[1] = pcv[7:0];
                cpu_sp -= 8'd2; nw = 2;
                cpu_pc = it.address;
            end
            M_RTS: begin cpu_sp += 8'd2; cpu_pc = {it.data_second, d} + 16'd1; end
            M_BRK: begin
                pcv = cpu_pc + 16'd1;
                wa[0] = StackPage + cpu_sp; wd[0] = pcv[15:8];
                wa[1] = StackPage + 8'(cpu_sp - 8'd1); wd[1] = pcv[7:0];
                wa[2] = StackPage + 8'(cpu_sp - 8'd2); wd[2] = cpu_p | 8'h30;
                cpu_sp -= 8'd3; nw = 3;
                cpu_p[FI] = 1'b1;
                cpu_pc = {it.data_second, d};
            end
            M_RTI: begin
                cpu_sp += 8'd3;
                cpu_p = (d | 8'h20) & 8'hEF;
                cpu_pc = {it.data_third, it.data_second};
            end
            M_PHA: begin wa[0] = StackPage + cpu_sp; wd[0] = cpu_a; cpu_sp--; nw = 1; end
            M_PLA: begin cpu_sp++; cpu_a = d; put_nz(d); end
            M_PHP: begin
                wa[0] = StackPage + cpu_sp; wd[0] = cpu_p | 8'h30; cpu_sp--; nw = 1;
            end
            M_PLP: begin cpu_sp++; cpu_p = (d | 8'h20) & 8'hEF; end
            M_TSX: begin cpu_x = cpu_sp; put_nz(cpu_x); end
            M_TXS: cpu_sp = cpu_x;
            M_CLC: cpu_p[FC] = 1'b0;
            M_SEC: cpu_p[FC] = 1'b1;
            M_CLI: cpu_p[FI] = 1'b0;
            M_SEI: cpu_p[FI] = 1'b1;
            M_CLD: cpu_p[FD] = 1'b0;
            M_SED: cpu_p[FD] = 1'b1;
            M_CLV: cpu_p[FV] = 1'b0;
            default: ;
        endcase
        // read-modify-write: dummy of the old byte, then the new one
        if (nw == 2 && it.mode inside {M_INC, M_DEC, M_ASL, M_LSR, M_ROL, M_ROR}) begin
            wa[0] = it.address; wd[0] = d;
            wa[1] = it.address; wd[1] = res;
            put_nz(res);
        end
        n = (nw == 0) ? 1 : nw;
        for (int k = 0; k < n; k++) begin
            o.bus_write   = nw != 0;
            o.bus_address = (nw != 0) ? wa[k] : 16'h0000;
            o.bus_data    = (nw != 0) ? wd[k] : 8'h00;
            o.acc_out = cpu_a; o.x_out = cpu_x; o.y_out = cpu_y;
            o.sp_out = cpu_sp; o.flags_out = cpu_p; o.pc_out = cpu_pc;
            o.last = (k == n - 1);
            bus_expect.push_back(o);
        end
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // sends one item and predicts it at acceptance; valid stays high unless a gap comes before the next item
    task automatic send_op(input t_in_item it, input bit quiet);
        int g;
        g = quiet ? 0 : gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (o_in_stall);
        execute_op(it);
    endtask

    function automatic t_in_item rand_op(input bit legal);
        t_in_item it;
        it.mode = legal ? 6'($urandom_range(0, 51)) : 6'($urandom_range(0, 63));
        it.address = 16'($urandom);
        it.data_first = 8'($urandom);
        it.data_second = 8'($urandom);
        it.data_third = 8'($urandom);
        return it;
    endfunction

    // output side: random stall and checking
    int stall_left = 0;
    bit quiet_out = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (bus_expect.size() == 0) begin
                    report("unexpected item", o_out, '0);
                end else begin
                    t_out_item w;
                    w = bus_expect.pop_front();
                    if (o_out.bus_write !== w.bus_write) report("bus_write", o_out, w);
                    if (o_out.bus_address !== w.bus_address) report("bus_address", o_out, w);
                    if (o_out.bus_data !== w.bus_data) report("bus_data", o_out, w);
                    if (o_out.acc_out !== w.acc_out) report("acc_out", o_out, w);
                    if (o_out.x_out !== w.x_out) report("x_out", o_out, w);
                    if (o_out.y_out !== w.y_out) report("y_out", o_out, w);
                    if (o_out.sp_out !== w.sp_out) report("sp_out", o_out, w);
                    if (o_out.flags_out !== w.flags_out) report("flags_out", o_out, w);
                    if (o_out.pc_out !== w.pc_out) report("pc_out", o_out, w);
                    if (o_out.last !== w.last) report("last", o_out, w);
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (quiet_out) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                stall_left <= gap_len();
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WatchLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // directed rows: expected typed in for the first reset-state ones
    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item want;
    } t_row;

    t_row rows[$];

    function automatic t_in_item mk(input t_mode m, input logic [15:0] a,
                                    input logic [7:0] d1, input logic [7:0] d2,
                                    input logic [7:0] d3);
        t_in_item it;
        it.mode = m; it.address = a;
        it.data_first = d1; it.data_second = d2; it.data_third = d3;
        return it;
    endfunction

    initial begin
        t_in_item it;
        t_out_item te;
        cpu_a = 8'h00; cpu_x = 8'h00; cpu_y = 8'h00;
        cpu_sp = SpReset; cpu_p = FlagReset; cpu_pc = 16'h0000;
        // nop after reset: registers at their reset values
        rows.push_back('{mk(M_NOP, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF), 1,
                         '{1'b0, 16'h0, 8'h0, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h24,
                           16'h0000, 1'b1}});
        // store of zero accumulator at top address
        rows.push_back('{mk(M_STA, 16'hFFFF, 8'h00, 8'h00, 8'h00), 1,
                         '{1'b1, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h24,
                           16'h0000, 1'b1}});
        rows.push_back('{mk(M_LDA, 16'h0, 8'h80, 8'h0, 8'h0), 1,
                         '{1'b0, 16'h0, 8'h0, 8'h80, 8'h00, 8'h00, 8'hFD, 8'hA4,
                           16'h0000, 1'b1}});
        rows.push_back('{mk(M_ADC, 16'h0, 8'h80, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_SBC, 16'h0, 8'h7F, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_INC, 16'h00FF, 8'hFF, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_ROR, 16'hFF00, 8'h01, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_JSR, 16'hABCD, 8'h0, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_BRK, 16'h0, 8'h34, 8'h12, 8'h0), 0, te});
        rows.push_back('{mk(M_PHP, 16'h0, 8'h0, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_RTI, 16'h0, 8'hFF, 8'hFF, 8'hFF), 0, te});
        rows.push_back('{mk(M_RTS, 16'h0, 8'hFF, 8'hFF, 8'h0), 0, te});
        rows.push_back('{mk(M_PLP, 16'h0, 8'h10, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_LDX, 16'h0, 8'h00, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_TXS, 16'h0, 8'h0, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_PHA, 16'h0, 8'h0, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_PLA, 16'h0, 8'h00, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_TSX, 16'h0, 8'h0, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_BIT, 16'h0, 8'hC0, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_CPY, 16'h0, 8'h01, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_DEY, 16'h0, 8'h0, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(M_SED, 16'h0, 8'h0, 8'h0, 8'h0), 0, te});
        rows.push_back('{mk(t_mode'(6'd63), 16'h5555, 8'hAA, 8'h55, 8'hAA), 0, te});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_op(rows[i].it, 0);
            if (rows[i].typed) begin
                // typed value replaces the predicted one; both must agree
                if (bus_expect[$] !== rows[i].want) report("table row", bus_expect[$], rows[i].want);
                bus_expect[$] = rows[i].want;
            end
        end
        // every mode once more, random content
        for (int m = 0; m < 52; m++) begin
            it = rand_op(1);
            it.mode = 6'(m);
            send_op(it, 0);
        end
        for (int n = 0; n < 300; n++) begin
            if (n == 150) begin
                i_in_valid <= 1'b0;
                wait (bus_expect.size() == 0);
                @(posedge i_clk);
            end
            // a stretch without gaps on either side
            quiet_out = (n >= 200 && n < 240);
            send_op(rand_op($urandom_range(0, 9) != 0), quiet_out);
        end
        i_in_valid <= 1'b0;
        quiet_out = 0;
        wait (bus_expect.size() == 0);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/c65eu_pkg.sv
rtl/core/c65eu_front.sv
rtl/core/c65eu_queue.sv
rtl/core/c65eu_back.sv
rtl/core/cpu6502_execute_unit.sv
rtl/core/c65eu_checker.sv
verif/tb.sv
